FILE: sv/qsl_pkg.sv
// Shared types and helpers for the quicksort sorter.
// No dependencies; used by quicksort_lomuto_sorter.
package qsl_pkg;

    // Element width of the sorted values
    localparam int unsigned VALUE_W = 32;

    // Sequencer states, one-hot
    typedef enum logic [16:0] {
        ST_IDLE     = 17'h00001,
        ST_PIV_RD   = 17'h00002,
        ST_HI_RD    = 17'h00004,
        ST_MID_WR   = 17'h00008,
        ST_SCAN_RD  = 17'h00010,
        ST_SCAN_CMP = 17'h00020,
        ST_SWAP_WI  = 17'h00040,
        ST_SWAP_WJ  = 17'h00080,
        ST_FIN_RD   = 17'h00100,
        ST_FIN_WH   = 17'h00200,
        ST_FIN_WI   = 17'h00400,
        ST_PUSH_L   = 17'h00800,
        ST_PUSH_R   = 17'h01000,
        ST_POP      = 17'h02000,
        ST_POP_WT   = 17'h04000,
        ST_EMIT     = 17'h08000,
        ST_DRAIN    = 17'h10000
    } t_state;

    // Signed ordering of two stored elements
    function automatic logic key_less(input logic [VALUE_W-1:0] a,
                                      input logic [VALUE_W-1:0] b);
        logic signed [VALUE_W-1:0] sa;
        logic signed [VALUE_W-1:0] sb;
        sa = $signed(a);
        sb = $signed(b);
        return sa < sb;
    endfunction

endpackage

FILE: sv/qsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the element store and the range stack.
module qsl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/quicksort_lomuto_sorter.sv
// Quicksort sorter top level: load, in-place Lomuto sort, ordered emission.
// Depends on qsl_pkg and qsl_ram (element store and range stack).
//
// Values are loaded one item per cycle while busy is low; at most MAX_ITEMS
// are kept and further values are dropped. An item with last set starts the
// sort; busy stays high until every sorted value has been sent. Each result
// is shown for one cycle with o_valid and cannot be held off; o_final_res
// marks the largest. The element store has a single read port, so a range
// is handled as a series of single memory accesses: set up the middle pivot,
// scan each element (with two writes for each swap), place the pivot and
// push and pop the range stack.
module quicksort_lomuto_sorter #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    output logic               o_valid,
    output logic signed [31:0] o_sorted_value,
    output logic               o_final_res
);

    localparam int unsigned VW  = qsl_pkg::VALUE_W;
    localparam int unsigned IW  = $clog2(MAX_ITEMS);
    localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SD  = MAX_ITEMS / 2;
    localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int unsigned SPW = $clog2(SD + 1);
    localparam int unsigned RW  = 2 * IW;

    localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_ITEMS);
    localparam logic [SPW-1:0] SP_MAX  = SPW'(SD);

    typedef struct packed {
        logic [IW-1:0] hi;
        logic [IW-1:0] lo;
    } t_range;

    // Control state
    qsl_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [SPW-1:0]  r_sp, n_sp;
    logic            r_out_v, n_out_v;

    // Working registers
    logic [IW-1:0]   r_lo, n_lo;
    logic [IW-1:0]   r_hi, n_hi;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_k, n_k;
    logic [VW-1:0]   r_piv, n_piv;
    logic [VW-1:0]   r_jval, n_jval;
    logic            r_out_last, n_out_last;

    // Element store port
    logic            e_we;
    logic [IW-1:0]   e_waddr;
    logic [VW-1:0]   e_wdata;
    logic [IW-1:0]   e_raddr;
    logic [VW-1:0]   e_rdata;

    // Range stack port
    logic            s_we;
    logic [SAW-1:0]  s_waddr;
    t_range          s_wdata;
    logic [SAW-1:0]  s_raddr;
    logic [RW-1:0]   s_rdata;
    t_range          s_pop;

    // Derived values
    logic            w_accept;
    logic            w_store;
    logic [CW-1:0]   w_n;
    logic [IW:0]     w_sum;
    logic [IW-1:0]   w_mid;
    logic [IW:0]     w_j1;
    logic            w_j_end;
    logic            w_less;
    logic            w_push_l;
    logic            w_push_r;
    logic [SPW-1:0]  w_sp_dec;
    logic [CW:0]     w_k1;

    qsl_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ITEMS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    qsl_ram #(
        .WIDTH (RW),
        .DEPTH (SD)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign busy     = (r_state != qsl_pkg::ST_IDLE);
    assign w_accept = start && !busy;
    assign w_store  = (r_cnt < CNT_MAX);
    assign w_n      = r_cnt + CW'(w_store);

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[IW:1];
    assign w_j1     = {1'b0, r_j} + (IW+1)'(1);
    assign w_j_end  = (w_j1 == {1'b0, r_hi});
    assign w_less   = qsl_pkg::key_less(e_rdata, r_piv);
    assign w_push_l = ({1'b0, r_i} > ({1'b0, r_lo} + (IW+1)'(1)));
    assign w_push_r = (({1'b0, r_i} + (IW+1)'(1)) < {1'b0, r_hi});
    assign w_sp_dec = r_sp - SPW'(1);
    assign w_k1     = (CW+1)'(r_k) + (CW+1)'(1);
    assign s_pop    = t_range'(s_rdata);

    // Sequencer: load, partition, stack handling, emission.
    // No read whose data is used hits an entry written in the same cycle,
    // so the store needs no forwarding.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sp       = r_sp;
        n_out_v    = 1'b0;
        n_out_last = r_out_last;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_piv      = r_piv;
        n_jval     = r_jval;
        e_we       = 1'b0;
        e_waddr    = r_i;
        e_wdata    = r_jval;
        e_raddr    = r_j;
        s_we       = 1'b0;
        s_waddr    = r_sp[SAW-1:0];
        s_wdata    = '{hi: r_hi, lo: r_lo};
        s_raddr    = w_sp_dec[SAW-1:0];

        case (r_state)
            qsl_pkg::ST_IDLE: begin
                // Store the item unless full; a last item starts the sort, or the emission for fewer than two items
                if (w_accept) begin
                    if (w_store) begin
                        e_we    = 1'b1;
                        e_waddr = r_cnt[IW-1:0];
                        e_wdata = i_value;
                    end
                    n_cnt = w_n;
                    if (i_last) begin
                        n_sp = '0;
                        n_k  = '0;
                        if (w_n < CW'(2)) begin
                            n_state = qsl_pkg::ST_EMIT;
                        end else begin
                            n_lo    = '0;
                            n_hi    = IW'(w_n - CW'(1));
                            n_state = qsl_pkg::ST_PIV_RD;
                        end
                    end
                end
            end
            qsl_pkg::ST_PIV_RD: begin
                e_raddr = w_mid;
                n_state = qsl_pkg::ST_HI_RD;
            end
            qsl_pkg::ST_HI_RD: begin
                // Middle element becomes the pivot; fetch the top of the range
                n_piv   = e_rdata;
                e_raddr = r_hi;
                n_state = qsl_pkg::ST_MID_WR;
            end
            qsl_pkg::ST_MID_WR: begin
                // Move the old top into the middle slot; pivot lives in r_piv
                e_we    = 1'b1;
                e_waddr = w_mid;
                e_wdata = e_rdata;
                n_i     = r_lo;
                n_j     = r_lo;
                n_state = qsl_pkg::ST_SCAN_RD;
            end
            qsl_pkg::ST_SCAN_RD: begin
                e_raddr = r_j;
                n_state = qsl_pkg::ST_SCAN_CMP;
            end
            qsl_pkg::ST_SCAN_CMP: begin
                n_jval = e_rdata;
                if (w_less && (r_i != r_j)) begin
                    e_raddr = r_i;
                    n_state = qsl_pkg::ST_SWAP_WI;
                end else begin
                    if (w_less) begin
                        n_i = r_i + IW'(1);
                    end
                    if (w_j_end) begin
                        n_state = qsl_pkg::ST_FIN_RD;
                    end else begin
                        n_j     = w_j1[IW-1:0];
                        n_state = qsl_pkg::ST_SCAN_RD;
                    end
                end
            end
            qsl_pkg::ST_SWAP_WI: begin
                e_we    = 1'b1;
                e_waddr = r_j;
                e_wdata = e_rdata;
                n_state = qsl_pkg::ST_SWAP_WJ;
            end
            qsl_pkg::ST_SWAP_WJ: begin
                e_we    = 1'b1;
                e_waddr = r_i;
                e_wdata = r_jval;
                n_i     = r_i + IW'(1);
                if (w_j_end) begin
                    n_state = qsl_pkg::ST_FIN_RD;
                end else begin
                    n_j     = w_j1[IW-1:0];
                    n_state = qsl_pkg::ST_SCAN_RD;
                end
            end
            qsl_pkg::ST_FIN_RD: begin
                e_raddr = r_i;
                n_state = qsl_pkg::ST_FIN_WH;
            end
            qsl_pkg::ST_FIN_WH: begin
                e_we    = 1'b1;
                e_waddr = r_hi;
                e_wdata = e_rdata;
                n_state = qsl_pkg::ST_FIN_WI;
            end
            qsl_pkg::ST_FIN_WI: begin
                // Drop the pivot into its final slot
                e_we    = 1'b1;
                e_waddr = r_i;
                e_wdata = r_piv;
                n_state = qsl_pkg::ST_PUSH_L;
            end
            qsl_pkg::ST_PUSH_L: begin
                if (w_push_l) begin
                    s_we    = 1'b1;
                    s_wdata = '{hi: r_i - IW'(1), lo: r_lo};
                    n_sp    = r_sp + SPW'(1);
                end
                n_state = qsl_pkg::ST_PUSH_R;
            end
            qsl_pkg::ST_PUSH_R: begin
                if (w_push_r) begin
                    s_we    = 1'b1;
                    s_wdata = '{hi: r_hi, lo: r_i + IW'(1)};
                    n_sp    = r_sp + SPW'(1);
                end
                n_state = qsl_pkg::ST_POP;
            end
            qsl_pkg::ST_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = qsl_pkg::ST_EMIT;
                end else begin
                    n_sp    = w_sp_dec;
                    n_state = qsl_pkg::ST_POP_WT;
                end
            end
            qsl_pkg::ST_POP_WT: begin
                n_lo = s_pop.lo;
                n_hi = s_pop.hi;
                if (s_pop.lo < s_pop.hi) begin
                    n_state = qsl_pkg::ST_PIV_RD;
                end else begin
                    n_state = qsl_pkg::ST_POP;
                end
            end
            qsl_pkg::ST_EMIT: begin
                // Stream the store out; read data is registered and appears in the cycle after its read
                e_raddr    = r_k;
                n_out_v    = 1'b1;
                n_out_last = (w_k1 == {1'b0, r_cnt});
                if (w_k1 == {1'b0, r_cnt}) begin
                    n_state = qsl_pkg::ST_DRAIN;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            qsl_pkg::ST_DRAIN: begin
                n_cnt   = '0;
                n_sp    = '0;
                n_state = qsl_pkg::ST_IDLE;
            end
            default: begin
                n_state = qsl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qsl_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_sp    <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sp    <= n_sp;
            r_out_v <= n_out_v;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_piv      <= n_piv;
        r_jval     <= n_jval;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_out_v;
    assign o_sorted_value = $signed(e_rdata);
    assign o_final_res    = r_out_v && r_out_last;

    // A result only follows an emission cycle
    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == qsl_pkg::ST_EMIT))
        else $error("result strobe without emission");

    // A swap always moves between two distinct slots with i below j
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsl_pkg::ST_SWAP_WI) |-> (r_i < r_j))
        else $error("swap with i not below j");

    // The scan never reaches the pivot slot
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsl_pkg::ST_SCAN_RD) |-> (r_j < r_hi && r_i <= r_j))
        else $error("scan index out of range");

    // A push never overflows the range stack
    a_stack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> (r_sp < SP_MAX))
        else $error("range stack overflow");

    // Loading is closed while a set is being sent: the count holds during emission
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsl_pkg::ST_EMIT) |=> (r_cnt == $past(r_cnt)))
        else $error("count changed during emission");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for quicksort_lomuto_sorter: loads sets of values,
// predicts the ascending order and checks every emitted value and final flag.
// Depends on qsl_pkg and the quicksort_lomuto_sorter RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned SET_DEPTH = 64;

    typedef logic signed [qsl_pkg::VALUE_W-1:0] t_elem;

    typedef struct packed {
        t_elem value;
        logic  is_last;
    } t_sorted_entry;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_elem i_value;
    logic  i_last;
    logic  o_valid;
    t_elem o_sorted_value;
    logic  o_final_res;

    // Values of the set being loaded, and emitted values still to come
    t_elem         load_set[$];
    t_sorted_entry pending_sorted[$];

    int  mismatch_count;
    int  items_sent;
    bit  no_idle;

    quicksort_lomuto_sorter #(
        .MAX_ITEMS(SET_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .o_sorted_value(o_sorted_value),
        .o_final_res   (o_final_res)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Order the loaded set ascending and queue one expected result per value
    task automatic predict_sorted_set();
        t_elem         key;
        t_sorted_entry entry;
        int            i;
        int            j;
        for (i = 1; i < load_set.size(); i++) begin
            key = load_set[i];
            j = i - 1;
            while (j >= 0 && load_set[j] > key) begin
                load_set[j + 1] = load_set[j];
                j--;
            end
            load_set[j + 1] = key;
        end
        for (i = 0; i < load_set.size(); i++) begin
            entry.value   = load_set[i];
            entry.is_last = (i == load_set.size() - 1);
            pending_sorted.push_back(entry);
        end
        load_set.delete();
    endtask

    // Store an accepted item; drop it once the set is full; a last item ends the set
    task automatic load_item(input t_elem v, input logic l);
        if (load_set.size() < SET_DEPTH) begin
            load_set.push_back(v);
        end
        if (l) begin
            predict_sorted_set();
        end
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // Send one item; returns just after the edge that accepts it
    task automatic send_item(input t_elem v, input logic l);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        do @(negedge i_clk); while (busy);
        load_item(v, l);
        @(posedge i_clk);
        items_sent++;
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_sorted.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Pick a value for the given content style
    function automatic t_elem make_value(input int style, input int idx, input int n);
        case (style)
            0: return t_elem'($urandom);
            1: return t_elem'($urandom_range(0, 7)) - 4;
            2: return t_elem'(idx * 1000 - 7);
            3: return t_elem'((n - idx) * 3);
            default: return t_elem'($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
        endcase
    endfunction

    // Send a set of n items, the final one marked last
    task automatic send_set(input int n, input int style);
        int k;
        for (k = 0; k < n; k++) begin
            send_item(make_value(style, k, n), k == n - 1);
        end
    endtask

    // Check each emitted value against the oldest expectation
    always @(negedge i_clk) begin
        t_sorted_entry want;
        if (i_rst_n && o_valid) begin
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected result value=%0d final=%0b", $time,
                         o_sorted_value, o_final_res);
                mismatch_count++;
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_value !== want.value) begin
                    $display("%0t: sorted_value expected %0d actual %0d", $time,
                             want.value, o_sorted_value);
                    mismatch_count++;
                end
                if (o_final_res !== want.is_last) begin
                    $display("%0t: final_res expected %0b actual %0b", $time,
                             want.is_last, o_final_res);
                    mismatch_count++;
                end
            end
        end
    end

    // Extremes of the value range, a single value and a reversed pair
    task automatic test_extremes();
        send_item(t_elem'(32'h7fff_ffff), 1'b0);
        send_item(t_elem'(32'h8000_0000), 1'b0);
        send_item(t_elem'(0), 1'b0);
        send_item(t_elem'(-1), 1'b0);
        send_item(t_elem'(1), 1'b0);
        send_item(t_elem'(32'h8000_0001), 1'b0);
        send_item(t_elem'(32'h7fff_fffe), 1'b1);
        send_item(t_elem'(-5), 1'b1);
        send_item(t_elem'(7), 1'b0);
        send_item(t_elem'(-7), 1'b1);
    endtask

    // Runs of equal values and an already sorted set
    task automatic test_equal_and_sorted();
        int k;
        for (k = 0; k < 6; k++) begin
            send_item(t_elem'(32'h1234_5678), k == 5);
        end
        send_set(5, 2);
    endtask

    // Fill the store, then send values that must be dropped, the last one marked
    task automatic test_store_full();
        int k;
        for (k = 0; k < SET_DEPTH + 2; k++) begin
            send_item(t_elem'($urandom), k == SET_DEPTH + 1);
        end
        // a new set must start from an empty store
        send_set(3, 0);
        wait_results_drained();
    endtask

    // Random sets, mostly small, with occasional full and overfull sets
    task automatic test_random_sets();
        int r;
        int n;
        while (items_sent < 160) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = $urandom_range(1, 8);
            end else if (r < 90) begin
                n = $urandom_range(9, 24);
            end else if (r < 97) begin
                n = $urandom_range(25, SET_DEPTH);
            end else begin
                n = SET_DEPTH + $urandom_range(1, 3);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            send_set(n, $urandom_range(0, 4));
            if ($urandom_range(0, 7) == 0) begin
                wait_results_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_value        = '0;
        i_last         = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        no_idle        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_equal_and_sorted();
        wait_results_drained();
        test_store_full();
        test_random_sets();

        // Drain everything still expected, then allow the block to settle
        start <= 1'b0;
        while (pending_sorted.size() != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_sorted.size() == 0) begin
            $display("quicksort_lomuto_sorter regression: pass");
        end else begin
            $display("quicksort_lomuto_sorter regression: fail");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("quicksort_lomuto_sorter regression: fail");
        $finish;
    end

endmodule
